FILE: rtl/rv64dec_pkg.sv
`default_nettype none

package rv64dec_pkg;

	// Major opcodes
	localparam logic [6:0] OPC_R     = 7'h33;
	localparam logic [6:0] OPC_I     = 7'h13;
	localparam logic [6:0] OPC_S     = 7'h23;
	localparam logic [6:0] OPC_L     = 7'h03;
	localparam logic [6:0] OPC_B     = 7'h63;
	localparam logic [6:0] OPC_IW    = 7'h1B;
	localparam logic [6:0] OPC_JALR  = 7'h67;
	localparam logic [6:0] OPC_JAL   = 7'h6F;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_LUI   = 7'h37;
	localparam logic [6:0] OPC_SYS   = 7'h73;
	localparam logic [6:0] OPC_RW    = 7'h3B;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MUL  = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 values
	localparam logic [2:0] F3_0 = 3'd0;
	localparam logic [2:0] F3_1 = 3'd1;
	localparam logic [2:0] F3_2 = 3'd2;
	localparam logic [2:0] F3_3 = 3'd3;
	localparam logic [2:0] F3_4 = 3'd4;
	localparam logic [2:0] F3_5 = 3'd5;
	localparam logic [2:0] F3_6 = 3'd6;
	localparam logic [2:0] F3_7 = 3'd7;

	// ECALL register overrides
	localparam logic [4:0] ECALL_RS1 = 5'd17;
	localparam logic [4:0] ECALL_RS2 = 5'd10;
	localparam logic [4:0] ECALL_RD  = 5'd10;

	// Dense operation codes
	localparam logic [5:0] OP_ILLEGAL = 6'd0;
	localparam logic [5:0] OP_ADD   = 6'd1;
	localparam logic [5:0] OP_MUL   = 6'd2;
	localparam logic [5:0] OP_SUB   = 6'd3;
	localparam logic [5:0] OP_SLL   = 6'd4;
	localparam logic [5:0] OP_MULH  = 6'd5;
	localparam logic [5:0] OP_SLT   = 6'd6;
	localparam logic [5:0] OP_XOR   = 6'd7;
	localparam logic [5:0] OP_DIV   = 6'd8;
	localparam logic [5:0] OP_SRL   = 6'd9;
	localparam logic [5:0] OP_SRA   = 6'd10;
	localparam logic [5:0] OP_OR    = 6'd11;
	localparam logic [5:0] OP_REM   = 6'd12;
	localparam logic [5:0] OP_AND   = 6'd13;
	localparam logic [5:0] OP_ADDI  = 6'd14;
	localparam logic [5:0] OP_SLLI  = 6'd15;
	localparam logic [5:0] OP_SLTI  = 6'd16;
	localparam logic [5:0] OP_XORI  = 6'd17;
	localparam logic [5:0] OP_SRLI  = 6'd18;
	localparam logic [5:0] OP_SRAI  = 6'd19;
	localparam logic [5:0] OP_ORI   = 6'd20;
	localparam logic [5:0] OP_ANDI  = 6'd21;
	localparam logic [5:0] OP_SB    = 6'd22;
	localparam logic [5:0] OP_SH    = 6'd23;
	localparam logic [5:0] OP_SW    = 6'd24;
	localparam logic [5:0] OP_SD    = 6'd25;
	localparam logic [5:0] OP_LB    = 6'd26;
	localparam logic [5:0] OP_LH    = 6'd27;
	localparam logic [5:0] OP_LW    = 6'd28;
	localparam logic [5:0] OP_LD    = 6'd29;
	localparam logic [5:0] OP_LBU   = 6'd30;
	localparam logic [5:0] OP_LHU   = 6'd31;
	localparam logic [5:0] OP_LWU   = 6'd32;
	localparam logic [5:0] OP_BEQ   = 6'd33;
	localparam logic [5:0] OP_BNE   = 6'd34;
	localparam logic [5:0] OP_BLT   = 6'd35;
	localparam logic [5:0] OP_BGE   = 6'd36;
	localparam logic [5:0] OP_ADD_IMM_W  = 6'd37;
	localparam logic [5:0] OP_SHL_IMM_W  = 6'd38;
	localparam logic [5:0] OP_SHR_IMM_W  = 6'd39;
	localparam logic [5:0] OP_SHRA_IMM_W = 6'd40;
	localparam logic [5:0] OP_JALR  = 6'd41;
	localparam logic [5:0] OP_JAL   = 6'd42;
	localparam logic [5:0] OP_PC_UPPER = 6'd43;
	localparam logic [5:0] OP_LUI   = 6'd44;
	localparam logic [5:0] OP_ENV_CALL = 6'd45;
	localparam logic [5:0] OP_ADDW  = 6'd46;
	localparam logic [5:0] OP_MULW  = 6'd47;
	localparam logic [5:0] OP_SUBW  = 6'd48;
	localparam logic [5:0] OP_SLLW  = 6'd49;
	localparam logic [5:0] OP_SRLW  = 6'd50;
	localparam logic [5:0] OP_SRAW  = 6'd51;
	localparam logic [5:0] OP_NOP   = 6'd52;

	typedef struct packed {
		logic [31:0] instruction_word;
		logic        load_in_execute;
		logic [4:0]  execute_dest_reg;
	} instr_t;

	typedef struct packed {
		logic [5:0]         op_code;
		logic               stall_res;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic               alu_uses_imm;
		logic               is_branch;
		logic [3:0]         store_bytes;
		logic [3:0]         load_bytes;
		logic               writes_reg;
		logic               result_from_memory;
	} decoded_t;

endpackage

`default_nettype wire

FILE: rtl/rv64im_decode_with_load_use_check.sv
// RV64IM decode stage with load-use hazard check.
// Input channel: instr_valid / instr_stall carry one instr_t item: the raw
// instruction word plus the load flag and destination register of the
// instruction now in execute. Output channel: res_valid / res_stall carry
// one decoded_t item per input item, in order.
// Decode is one pass of combinational logic into the result register, and
// one item is taken every cycle while res_stall stays low.
// A skid register sits behind the result register: when the receiver
// stalls, one more item is still taken and held, then instr_stall rises
// until the result register drains. No item is dropped or repeated.
// nop_opcode_we / nop_opcode_wdata write the private NOP opcode; write it
// only while the block holds no item.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// NOP opcode to zero.
`default_nettype none

module rv64im_decode_with_load_use_check
	import rv64dec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       nop_opcode_we,
	input  wire logic [6:0] nop_opcode_wdata,
	input  wire logic       instr_valid,
	output logic            instr_stall,
	input  wire instr_t     instr,
	output logic            res_valid,
	input  wire logic       res_stall,
	output decoded_t        res
);

	logic [6:0] nop_opcode_q;
	decoded_t   res_s1;
	decoded_t   skid_q;
	logic       res_valid_q;
	logic       skid_valid_q;
	decoded_t   dec;
	logic       accept;
	logic       res_free;

	// Instruction fields
	logic [31:0] w;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;

	assign w     = instr.instruction_word;
	assign opc   = w[6:0];
	assign f3    = w[14:12];
	assign f7    = w[31:25];
	assign imm_i = {{20{w[31]}}, w[31:20]};
	assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
	assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
	assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
	assign imm_u = {w[31:12], 12'd0};

	// Decode one instruction and apply the hazard check
	always_comb begin
		logic [5:0]  code;
		logic [31:0] imm;
		logic        alu_imm;
		logic        br;
		logic [3:0]  st;
		logic [3:0]  ld;
		logic        wr;
		logic        m2r;
		code    = OP_ILLEGAL;
		imm     = 32'd0;
		alu_imm = 1'b0;
		br      = 1'b0;
		st      = 4'd0;
		ld      = 4'd0;
		wr      = 1'b0;
		m2r     = 1'b0;
		rd      = w[11:7];
		rs1     = w[19:15];
		rs2     = w[24:20];
		case (opc)
			OPC_R: begin
				wr = 1'b1;
				case ({f7, f3})
					{F7_BASE, F3_0}: code = OP_ADD;
					{F7_MUL,  F3_0}: code = OP_MUL;
					{F7_ALT,  F3_0}: code = OP_SUB;
					{F7_BASE, F3_1}: code = OP_SLL;
					{F7_MUL,  F3_1}: code = OP_MULH;
					{F7_BASE, F3_2}: code = OP_SLT;
					{F7_BASE, F3_4}: code = OP_XOR;
					{F7_MUL,  F3_4}: code = OP_DIV;
					{F7_BASE, F3_5}: code = OP_SRL;
					{F7_ALT,  F3_5}: code = OP_SRA;
					{F7_BASE, F3_6}: code = OP_OR;
					{F7_MUL,  F3_6}: code = OP_REM;
					{F7_BASE, F3_7}: code = OP_AND;
					default:         code = OP_ILLEGAL;
				endcase
			end
			OPC_I: begin
				wr      = 1'b1;
				alu_imm = 1'b1;
				imm     = imm_i;
				case (f3)
					F3_0:    code = OP_ADDI;
					F3_1:    code = OP_SLLI;
					F3_2:    code = OP_SLTI;
					F3_4:    code = OP_XORI;
					F3_5:    code = w[30] ? OP_SRAI : OP_SRLI;
					F3_6:    code = OP_ORI;
					F3_7:    code = OP_ANDI;
					default: code = OP_ILLEGAL;
				endcase
			end
			OPC_S: begin
				alu_imm = 1'b1;
				imm     = imm_s;
				if (!f3[2]) begin
					code = OP_SB + {4'd0, f3[1:0]};
					st   = 4'd1 << f3[1:0];
				end
			end
			OPC_L: begin
				alu_imm = 1'b1;
				imm     = imm_i;
				wr      = 1'b1;
				m2r     = 1'b1;
				if (f3 != F3_7) begin
					code = OP_LB + {3'd0, f3};
					ld   = 4'd1 << f3[1:0];
				end
			end
			OPC_B: begin
				br  = 1'b1;
				imm = imm_b;
				case (f3)
					F3_0:    code = OP_BEQ;
					F3_1:    code = OP_BNE;
					F3_4:    code = OP_BLT;
					F3_5:    code = OP_BGE;
					default: code = OP_ILLEGAL;
				endcase
			end
			OPC_IW: begin
				wr      = 1'b1;
				alu_imm = 1'b1;
				imm     = imm_i;
				case ({f7, f3})
					{F7_BASE, F3_5}: code = OP_SHR_IMM_W;
					{F7_ALT,  F3_5}: code = OP_SHRA_IMM_W;
					default: begin
						if (f3 == F3_0)
							code = OP_ADD_IMM_W;
						else if (f3 == F3_1)
							code = OP_SHL_IMM_W;
						else
							code = OP_ILLEGAL;
					end
				endcase
			end
			OPC_JALR: begin
				br   = 1'b1;
				wr   = 1'b1;
				imm  = imm_i;
				code = OP_JALR;
			end
			OPC_JAL: begin
				br   = 1'b1;
				wr   = 1'b1;
				imm  = imm_j;
				code = OP_JAL;
			end
			OPC_AUIPC: begin
				wr   = 1'b1;
				imm  = imm_u;
				code = OP_PC_UPPER;
			end
			OPC_LUI: begin
				wr   = 1'b1;
				imm  = imm_u;
				code = OP_LUI;
			end
			OPC_SYS: begin
				wr   = 1'b1;
				code = OP_ENV_CALL;
				rs1  = ECALL_RS1;
				rs2  = ECALL_RS2;
				rd   = ECALL_RD;
			end
			OPC_RW: begin
				wr = 1'b1;
				case ({f7, f3})
					{F7_BASE, F3_0}: code = OP_ADDW;
					{F7_MUL,  F3_0}: code = OP_MULW;
					{F7_ALT,  F3_0}: code = OP_SUBW;
					{F7_BASE, F3_1}: code = OP_SLLW;
					{F7_BASE, F3_5}: code = OP_SRLW;
					{F7_ALT,  F3_5}: code = OP_SRAW;
					default:         code = OP_ILLEGAL;
				endcase
			end
			default: begin
				if (opc == nop_opcode_q)
					code = OP_NOP;
			end
		endcase

		dec = '0;
		if (code != OP_ILLEGAL) begin
			if (instr.load_in_execute &&
			    (instr.execute_dest_reg == rs1 || instr.execute_dest_reg == rs2)) begin
				// Load-use hazard: send a bubble
				dec.stall_res = 1'b1;
			end else begin
				dec.op_code            = code;
				dec.dest_reg           = rd;
				dec.src1_reg           = rs1;
				dec.src2_reg           = rs2;
				dec.immediate          = imm;
				dec.alu_uses_imm       = alu_imm;
				dec.is_branch          = br;
				dec.store_bytes        = st;
				dec.load_bytes         = ld;
				dec.writes_reg         = wr;
				dec.result_from_memory = m2r;
			end
		end
	end

	// Handshake: result register frees when empty or taken this cycle
	assign instr_stall = skid_valid_q;
	assign accept      = instr_valid && !skid_valid_q;
	assign res_free    = !res_valid_q || !res_stall;
	assign res_valid   = res_valid_q;
	assign res         = res_s1;

	// Hold the NOP opcode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nop_opcode_q <= 7'd0;
		end else if (nop_opcode_we) begin
			nop_opcode_q <= nop_opcode_wdata;
		end
	end

	// Advance valid flags of result and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_free) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Load payloads: skid drains first, else the new item
	always_ff @(posedge clk) begin
		if (res_free) begin
			if (skid_valid_q) begin
				res_s1 <= skid_q;
			end else if (accept) begin
				res_s1 <= dec;
			end
		end else if (accept) begin
			skid_q <= dec;
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb_rv64im_decode_with_load_use_check.sv
module tb_rv64im_decode_with_load_use_check
	import rv64dec_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 330;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_e;

	// Decoded-instruction scoreboard: predicts each accepted instruction and
	// matches the decoder output against the oldest prediction.
	class decode_scoreboard;
		decoded_t pending[$];
		logic [6:0] nop_op;
		int errors;

		function new();
			nop_op = '0;
			errors = 0;
		endfunction

		function decoded_t decode_instr(instr_t x);
			logic [31:0] w;
			logic [6:0] opc;
			logic [6:0] f7;
			logic [2:0] f3;
			logic [4:0] rd;
			logic [4:0] rs1;
			logic [4:0] rs2;
			logic [5:0] code;
			logic [31:0] imm;
			logic alu_imm;
			logic br;
			logic wr;
			logic m2r;
			logic [3:0] st;
			logic [3:0] ld;
			logic [31:0] imm_i;
			logic [31:0] imm_s;
			logic [31:0] imm_b;
			logic [31:0] imm_j;
			logic [31:0] imm_u;
			decoded_t d;
			w = x.instruction_word;
			opc = w[6:0];
			f3 = w[14:12];
			f7 = w[31:25];
			rd = w[11:7];
			rs1 = w[19:15];
			rs2 = w[24:20];
			imm_i = {{20{w[31]}}, w[31:20]};
			imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
			imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			imm_u = {w[31:12], 12'b0};
			code = OP_ILLEGAL;
			imm = '0;
			alu_imm = 1'b0;
			br = 1'b0;
			wr = 1'b0;
			m2r = 1'b0;
			st = '0;
			ld = '0;
			d = '0;

			// decode the major opcode, then funct3/funct7
			case (opc)
				OPC_R: begin
					wr = 1'b1;
					case ({f7, f3})
						{F7_BASE, F3_0}: code = OP_ADD;
						{F7_MUL, F3_0}:  code = OP_MUL;
						{F7_ALT, F3_0}:  code = OP_SUB;
						{F7_BASE, F3_1}: code = OP_SLL;
						{F7_MUL, F3_1}:  code = OP_MULH;
						{F7_BASE, F3_2}: code = OP_SLT;
						{F7_BASE, F3_4}: code = OP_XOR;
						{F7_MUL, F3_4}:  code = OP_DIV;
						{F7_BASE, F3_5}: code = OP_SRL;
						{F7_ALT, F3_5}:  code = OP_SRA;
						{F7_BASE, F3_6}: code = OP_OR;
						{F7_MUL, F3_6}:  code = OP_REM;
						{F7_BASE, F3_7}: code = OP_AND;
						default:         code = OP_ILLEGAL;
					endcase
				end
				OPC_I: begin
					wr = 1'b1;
					alu_imm = 1'b1;
					imm = imm_i;
					case (f3)
						F3_0:    code = OP_ADDI;
						F3_1:    code = OP_SLLI;
						F3_2:    code = OP_SLTI;
						F3_4:    code = OP_XORI;
						F3_5:    code = w[30] ? OP_SRAI : OP_SRLI;
						F3_6:    code = OP_ORI;
						F3_7:    code = OP_ANDI;
						default: code = OP_ILLEGAL;
					endcase
				end
				OPC_S: begin
					alu_imm = 1'b1;
					imm = imm_s;
					if (f3 < F3_4) begin
						code = OP_SB + {3'd0, f3};
						st = 4'd1 << f3[1:0];
					end
				end
				OPC_L: begin
					alu_imm = 1'b1;
					imm = imm_i;
					wr = 1'b1;
					m2r = 1'b1;
					if (f3 != F3_7) begin
						code = OP_LB + {3'd0, f3};
						ld = 4'd1 << f3[1:0];
					end
				end
				OPC_B: begin
					br = 1'b1;
					imm = imm_b;
					case (f3)
						F3_0:    code = OP_BEQ;
						F3_1:    code = OP_BNE;
						F3_4:    code = OP_BLT;
						F3_5:    code = OP_BGE;
						default: code = OP_ILLEGAL;
					endcase
				end
				OPC_IW: begin
					wr = 1'b1;
					alu_imm = 1'b1;
					imm = imm_i;
					if (f3 == F3_0) code = OP_ADD_IMM_W;
					else if (f3 == F3_1) code = OP_SHL_IMM_W;
					else if (f3 == F3_5 && f7 == F7_BASE) code = OP_SHR_IMM_W;
					else if (f3 == F3_5 && f7 == F7_ALT) code = OP_SHRA_IMM_W;
				end
				OPC_JALR: begin
					br = 1'b1;
					wr = 1'b1;
					imm = imm_i;
					code = OP_JALR;
				end
				OPC_JAL: begin
					br = 1'b1;
					wr = 1'b1;
					imm = imm_j;
					code = OP_JAL;
				end
				OPC_AUIPC: begin
					wr = 1'b1;
					imm = imm_u;
					code = OP_PC_UPPER;
				end
				OPC_LUI: begin
					wr = 1'b1;
					imm = imm_u;
					code = OP_LUI;
				end
				OPC_SYS: begin
					wr = 1'b1;
					code = OP_ENV_CALL;
					rs1 = ECALL_RS1;
					rs2 = ECALL_RS2;
					rd = ECALL_RD;
				end
				OPC_RW: begin
					wr = 1'b1;
					case ({f7, f3})
						{F7_BASE, F3_0}: code = OP_ADDW;
						{F7_MUL, F3_0}:  code = OP_MULW;
						{F7_ALT, F3_0}:  code = OP_SUBW;
						{F7_BASE, F3_1}: code = OP_SLLW;
						{F7_BASE, F3_5}: code = OP_SRLW;
						{F7_ALT, F3_5}:  code = OP_SRAW;
						default:         code = OP_ILLEGAL;
					endcase
				end
				default: begin
					if (opc == nop_op) code = OP_NOP;
				end
			endcase

			// illegal stays all zero; a load-use hazard sends a bubble
			if (code != OP_ILLEGAL) begin
				if (x.load_in_execute &&
				    (x.execute_dest_reg == rs1 || x.execute_dest_reg == rs2)) begin
					d.stall_res = 1'b1;
				end else begin
					d.op_code = code;
					d.dest_reg = rd;
					d.src1_reg = rs1;
					d.src2_reg = rs2;
					d.immediate = imm;
					d.alu_uses_imm = alu_imm;
					d.is_branch = br;
					d.store_bytes = st;
					d.load_bytes = ld;
					d.writes_reg = wr;
					d.result_from_memory = m2r;
				end
			end
			return d;
		endfunction

		function void note_instr(instr_t x);
			pending.push_back(decode_instr(x));
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(decoded_t got);
			decoded_t want;
			if (pending.size() == 0) begin
				$display("%0t: result with no pending instruction, expected none, actual op %0d",
					$time, got.op_code);
				errors++;
				return;
			end
			want = pending.pop_front();
			cmp_field("op_code", 32'(want.op_code), 32'(got.op_code));
			cmp_field("stall_res", 32'(want.stall_res), 32'(got.stall_res));
			cmp_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
			cmp_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
			cmp_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
			cmp_field("immediate", want.immediate, got.immediate);
			cmp_field("alu_uses_imm", 32'(want.alu_uses_imm), 32'(got.alu_uses_imm));
			cmp_field("is_branch", 32'(want.is_branch), 32'(got.is_branch));
			cmp_field("store_bytes", 32'(want.store_bytes), 32'(got.store_bytes));
			cmp_field("load_bytes", 32'(want.load_bytes), 32'(got.load_bytes));
			cmp_field("writes_reg", 32'(want.writes_reg), 32'(got.writes_reg));
			cmp_field("result_from_memory", 32'(want.result_from_memory),
				32'(got.result_from_memory));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic nop_opcode_we;
	logic [6:0] nop_opcode_wdata;
	logic instr_valid;
	logic instr_stall;
	instr_t instr;
	logic res_valid;
	logic res_stall = 1'b0;
	decoded_t res;

	decode_scoreboard sb;
	stall_mode_e stall_mode = STALL_NONE;
	int stall_left = 0;
	int cyc = 0;
	int quiet_cycles = 0;

	rv64im_decode_with_load_use_check i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.nop_opcode_we    (nop_opcode_we),
		.nop_opcode_wdata (nop_opcode_wdata),
		.instr_valid      (instr_valid),
		.instr_stall      (instr_stall),
		.instr            (instr),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.res              (res)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Receiver stall pattern: switch mode every so often
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (stall_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default:     res_stall <= (cyc[3:0] < 4'd10);
		endcase
	end

	// Check every result the decoder hands over
	always @(posedge clk) begin
		if (res_valid && !res_stall) sb.check_result(res);
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if ((instr_valid && !instr_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[rv64im_decode_with_load_use_check] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] enc(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
			logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// Random instruction, mostly real opcodes with likely funct7 values
	function automatic instr_t gen_instr();
		logic [31:0] w;
		instr_t x;
		w = $urandom;
		case ($urandom_range(0, 15))
			0:  w[6:0] = OPC_R;
			1:  w[6:0] = OPC_I;
			2:  w[6:0] = OPC_S;
			3:  w[6:0] = OPC_L;
			4:  w[6:0] = OPC_B;
			5:  w[6:0] = OPC_IW;
			6:  w[6:0] = OPC_JALR;
			7:  w[6:0] = OPC_JAL;
			8:  w[6:0] = OPC_AUIPC;
			9:  w[6:0] = OPC_LUI;
			10: w[6:0] = OPC_SYS;
			11: w[6:0] = OPC_RW;
			12, 13: w[6:0] = sb.nop_op;
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: w[31:25] = F7_BASE;
			1: w[31:25] = F7_MUL;
			2: w[31:25] = F7_ALT;
			default: ;
		endcase
		x.instruction_word = w;
		x.load_in_execute = ($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 3))
			0: x.execute_dest_reg = w[19:15];
			1: x.execute_dest_reg = w[24:20];
			2: x.execute_dest_reg = $urandom_range(0, 1) ? ECALL_RS1 : ECALL_RS2;
			default: x.execute_dest_reg = 5'($urandom);
		endcase
		return x;
	endfunction

	// Present one item and hold it until taken
	task automatic send_instr(instr_t x);
		instr_valid <= 1'b1;
		instr <= x;
		@(posedge clk);
		while (instr_stall) @(posedge clk);
		sb.note_instr(x);
	endtask

	task automatic idle(int n);
		instr_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		instr_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Write the NOP opcode once the decoder is empty
	task automatic write_nop(logic [6:0] v);
		drain();
		nop_opcode_we <= 1'b1;
		nop_opcode_wdata <= v;
		@(posedge clk);
		nop_opcode_we <= 1'b0;
		sb.nop_op = v;
	endtask

	// Bursts of back-to-back items with random gaps
	task automatic run_random(int n);
		int burst;
		burst = $urandom_range(1, 40);
		for (int i = 0; i < n; i++) begin
			send_instr(gen_instr());
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
				burst = $urandom_range(1, 40);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		nop_opcode_we <= 1'b0;
		nop_opcode_wdata <= '0;
		instr_valid <= 1'b0;
		instr <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero word is the NOP after reset; x0 counts for the hazard
		send_instr({32'h0000_0000, 1'b0, 5'd0});
		send_instr({32'h0000_0000, 1'b1, 5'd0});
		// illegal word never raises a stall
		send_instr({32'hFFFF_FFFF, 1'b1, 5'd31});
		send_instr({enc(OPC_R, F3_0, F7_BASE, 5'd1, 5'd2, 5'd3), 1'b1, 5'd4});
		send_instr({enc(OPC_R, F3_6, F7_MUL, 5'd5, 5'd6, 5'd7), 1'b1, 5'd7});
		send_instr({enc(OPC_R, F3_3, F7_MUL, 5'd31, 5'd31, 5'd31), 1'b0, 5'd0});
		// shift immediates: only bit 30 picks arithmetic, SLLI ignores the top bits
		send_instr({enc(OPC_I, F3_5, 7'b0100000, 5'd9, 5'd10, 5'd31), 1'b0, 5'd0});
		send_instr({enc(OPC_I, F3_5, 7'b1011111, 5'd9, 5'd10, 5'd0), 1'b0, 5'd0});
		send_instr({enc(OPC_I, F3_1, 7'h7F, 5'd31, 5'd0, 5'd31), 1'b0, 5'd0});
		send_instr({enc(OPC_I, F3_3, F7_BASE, 5'd1, 5'd1, 5'd1), 1'b0, 5'd0});
		send_instr({enc(OPC_I, F3_0, 7'h40, 5'd0, 5'd31, 5'd0), 1'b1, 5'd30});
		send_instr({enc(OPC_S, F3_3, 7'h7F, 5'd31, 5'd2, 5'd3), 1'b0, 5'd0});
		send_instr({enc(OPC_S, F3_4, 7'h3F, 5'd0, 5'd2, 5'd3), 1'b0, 5'd0});
		send_instr({enc(OPC_L, F3_3, 7'h7F, 5'd8, 5'd12, 5'd31), 1'b0, 5'd0});
		send_instr({enc(OPC_L, F3_6, F7_BASE, 5'd8, 5'd12, 5'd1), 1'b0, 5'd0});
		send_instr({enc(OPC_L, F3_7, F7_BASE, 5'd8, 5'd12, 5'd1), 1'b0, 5'd0});
		send_instr({enc(OPC_B, F3_5, 7'h7F, 5'd31, 5'd1, 5'd2), 1'b0, 5'd0});
		send_instr({enc(OPC_B, F3_2, F7_BASE, 5'd0, 5'd1, 5'd2), 1'b0, 5'd0});
		send_instr({enc(OPC_JAL, F3_7, 7'h40, 5'd1, 5'd0, 5'd0), 1'b0, 5'd0});
		send_instr({enc(OPC_JALR, F3_7, 7'h3F, 5'd1, 5'd5, 5'd31), 1'b0, 5'd0});
		send_instr({enc(OPC_LUI, F3_7, 7'h7F, 5'd31, 5'd31, 5'd31), 1'b0, 5'd0});
		// ECALL: junk in the upper bits, hazard only on the forced registers
		send_instr({32'hFFFF_FFF3, 1'b1, 5'd31});
		send_instr({32'hFFFF_FFF3, 1'b1, ECALL_RS1});
		send_instr({32'h0000_0073, 1'b1, ECALL_RS2});
		send_instr({enc(OPC_IW, F3_5, F7_ALT, 5'd3, 5'd4, 5'd5), 1'b0, 5'd0});
		send_instr({enc(OPC_IW, F3_1, 7'h7F, 5'd3, 5'd4, 5'd5), 1'b0, 5'd0});
		send_instr({enc(OPC_IW, F3_5, F7_MUL, 5'd3, 5'd4, 5'd5), 1'b0, 5'd0});
		send_instr({enc(OPC_RW, F3_5, F7_ALT, 5'd3, 5'd4, 5'd5), 1'b0, 5'd0});
		send_instr({enc(OPC_RW, F3_1, F7_MUL, 5'd3, 5'd4, 5'd5), 1'b0, 5'd0});

		// random phases over several NOP opcode settings
		run_random(PHASE_ITEMS);
		write_nop(7'h7F);
		run_random(PHASE_ITEMS);
		write_nop(OPC_R);
		run_random(PHASE_ITEMS);
		write_nop(7'h0B);
		run_random(PHASE_ITEMS);
		write_nop(7'h00);
		run_random(PHASE_ITEMS);
		write_nop(7'($urandom_range(0, 127)));
		run_random(PHASE_ITEMS);

		drain();
		repeat (3) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0, actual %0d",
				$time, sb.pending.size(), sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("[rv64im_decode_with_load_use_check] OK");
		end else begin
			$display("[rv64im_decode_with_load_use_check] ERROR");
		end
		$finish;
	end

endmodule

FILE: rv64im_decode_with_load_use_check.f
rtl/rv64dec_pkg.sv
rtl/rv64im_decode_with_load_use_check.sv
bench/tb_rv64im_decode_with_load_use_check.sv
